[hdl/mig_pkg.sv]
// Shared types, constants and hash tables for the mnemonic index generator.
package mig_pkg;

  localparam int INDEX_BITS = 11;
  localparam int LEN_MIN    = 4;
  localparam int LEN_MAX    = 8;
  localparam int LEN_RESET  = 4;

  localparam logic REG_LEN = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FIN,
    ST_RD,
    ST_TK,
    ST_OUT
  } mig_state_t;

  typedef struct packed {
    logic       init;
    logic       shift;
    logic [7:0] data;
    logic       round;
    logic [5:0] rnd;
  } sha_ctl_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

[hdl/mig_sha.sv]
// SHA-256 round engine with a sliding sixteen-word schedule window.
module mig_sha
  import mig_pkg::*;
(
  input  logic        clk,
  input  sha_ctl_t    ctl,
  output logic [31:0] a_o
);

  logic [31:0] win_r [16];
  logic [31:0] v_r   [8];
  logic [31:0] s0w, s1w, wnext, s0v, s1v, chv, majv, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    s0w   = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1w   = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    wnext = win_r[0] + s0w + win_r[9] + s1w;
    s1v   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    chv   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + s1v + chv + KTAB[ctl.rnd] + win_r[0];
    s0v   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    majv  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = s0v + majv;
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_r[15] <= {win_r[15][23:0], ctl.data};
    end else if (ctl.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= wnext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= IV[i];
      end
    end else if (ctl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign a_o = v_r[0];

endmodule

[hdl/mnemonic_index_generator_top.sv]
// Top level: entropy store, APB register, hashing sequence and index emission.
//
// Entropy bytes are taken one per cycle into a synchronous byte store. After
// the last byte the block streams the padded block into the hash window,
// runs the hash rounds (one round per cycle) and forms the checksum, then
// emits 3 * length_words indices; each index needs one or two store reads
// before it is offered at the output, and the whole mnemonic reads every
// entropy byte and the checksum byte once. The hash round loop and the single
// store read port bound the throughput. No input is taken while the hash runs
// or indices are emitted.
module mnemonic_index_generator_top
  import mig_pkg::*;
#(
  parameter int MAX_ENTROPY_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_entropy_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_word_index,
  output logic        out_last_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_ENTROPY_BYTES);

  mig_state_t  st_r, st_nxt;
  logic [3:0]  len_r;
  logic [5:0]  cnt_r;
  logic [6:0]  li_r;
  logic [5:0]  rc_r;
  logic [5:0]  b_r;
  logic [4:0]  bits_r;
  logic [8:0]  used_r;
  logic [18:0] acc_r;
  logic [7:0]  chk_r;
  logic [7:0]  mem [MAX_ENTROPY_BYTES];
  logic [7:0]  rdata_r;

  logic [3:0]  wl;
  logic [5:0]  n;
  logic [3:0]  cs;
  logic [8:0]  total;
  logic [7:0]  cmask;
  logic        cfg_wr;
  logic        in_acc, out_acc, last;
  logic        rd_en;
  logic [5:0]  rd_pos, jb;
  logic [7:0]  ld_byte, tk_byte;
  logic [8:0]  nbits;
  logic [31:0] a_w, h0;
  logic [4:0]  sh;
  sha_ctl_t    ctl;

  always_comb begin
    if (len_r < 4'(LEN_MIN)) begin
      wl = 4'(LEN_MIN);
    end else if (len_r > 4'(LEN_MAX)) begin
      wl = 4'(LEN_MAX);
    end else begin
      wl = len_r;
    end
    n = {wl, 2'b00};
    if (n > 6'(MAX_ENTROPY_BYTES)) begin
      n = 6'(MAX_ENTROPY_BYTES);
    end
    cs    = n[5:2];
    total = {n, 3'b000} + 9'(cs);
    cmask = 8'(8'hff << (4'd8 - cs));
    nbits = 9'(n) << 3;
  end

  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_LEN) ? {28'b0, len_r} : 32'b0;
  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;
  assign last    = (10'(used_r) + 10'd22) > 10'(total);
  assign jb      = 6'(li_r - 7'd1);

  always_comb begin
    if (jb < n) begin
      ld_byte = rdata_r;
    end else if (jb == n) begin
      ld_byte = 8'h80;
    end else if (jb == 6'd62) begin
      ld_byte = 8'(nbits >> 8);
    end else if (jb == 6'd63) begin
      ld_byte = nbits[7:0];
    end else begin
      ld_byte = 8'h00;
    end
    tk_byte = (b_r < n) ? rdata_r : chk_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_acc && (cnt_r + 6'd1 >= n) && !cfg_wr) st_nxt = ST_LOAD;
      ST_LOAD:  if (li_r == 7'd64) st_nxt = ST_ROUND;
      ST_ROUND: if (rc_r == 6'd63) st_nxt = ST_FIN;
      ST_FIN:   st_nxt = ST_RD;
      ST_RD:    st_nxt = ST_TK;
      ST_TK:    st_nxt = (bits_r + 5'd8 >= 5'(INDEX_BITS)) ? ST_OUT : ST_RD;
      ST_OUT:   if (out_acc) st_nxt = last ? ST_IDLE : ST_RD;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    rd_pos    = b_r;
    ctl       = '0;
    ctl.rnd   = rc_r;
    ctl.data  = ld_byte;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.init = 1'b1;
      end
      ST_LOAD: begin
        rd_pos    = li_r[5:0];
        rd_en     = (li_r < 7'd64) && (li_r[5:0] < n);
        ctl.shift = (li_r != 7'd0);
      end
      ST_ROUND: ctl.round = 1'b1;
      ST_RD:    rd_en = (b_r < n);
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  mig_sha u_sha (
    .clk (clk),
    .ctl (ctl),
    .a_o (a_w)
  );

  always_ff @(posedge clk) begin
    if (in_acc && cnt_r < 6'(MAX_ENTROPY_BYTES)) begin
      mem[cnt_r[AW-1:0]] <= in_entropy_byte;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_pos[AW-1:0]];
    end
  end

  assign h0 = IV[0] + a_w;
  assign sh = bits_r - 5'(INDEX_BITS);
  assign out_word_index = 11'(acc_r >> sh);
  assign out_last_word  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      len_r <= 4'(LEN_RESET);
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr && paddr[2] == REG_LEN) begin
        len_r <= pwdata[3:0];
        cnt_r <= '0;
      end else if (in_acc) begin
        cnt_r <= (cnt_r + 6'd1 >= n) ? 6'd0 : cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        li_r <= '0;
        rc_r <= '0;
      end
      ST_LOAD:  li_r <= li_r + 7'd1;
      ST_ROUND: rc_r <= rc_r + 6'd1;
      ST_FIN: begin
        chk_r  <= h0[31:24] & cmask;
        b_r    <= '0;
        bits_r <= '0;
        used_r <= '0;
      end
      ST_TK: begin
        acc_r  <= {acc_r[10:0], tk_byte};
        bits_r <= bits_r + 5'd8;
        b_r    <= b_r + 6'd1;
      end
      ST_OUT: begin
        if (out_acc) begin
          bits_r <= bits_r - 5'(INDEX_BITS);
          used_r <= used_r + 9'(INDEX_BITS);
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken during emission");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < n) else $error("byte count beyond length");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_word) |=> in_ready) else $error("no return to idle");
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (bits_r >= 5'(INDEX_BITS))) else $error("index short of bits");
`endif

endmodule
